// ===== sv/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;
    localparam logic [3:0] OPCODE_CLOSE = 4'd8;

    // one result word
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       data_valid;
        logic       frame_last;
        logic [3:0] frame_opcode;
        logic       is_close;
    } wsd_result_t;

endpackage

// ===== sv/wsd_in_reg.sv =====
// ----------------------------------------------------------------------------
// wsd_in_reg
// input register: holds one received byte until the parser takes it
// ----------------------------------------------------------------------------
module wsd_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] byte_reg;
    logic       load;

    // stall only when a word is held and the parser cannot take it
    assign in_stall = vld_reg && !take;
    assign load     = in_valid && !in_stall;
    assign vld_next = load ? 1'b1 : (take ? 1'b0 : vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign held_valid = vld_reg;
    assign held_byte  = byte_reg;

endmodule

// ===== sv/wsd_parse.sv =====
// ----------------------------------------------------------------------------
// wsd_parse
// frame header parser, length and key capture, payload unmasking
// ----------------------------------------------------------------------------
module wsd_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 held_valid,
    input  logic [7:0]           held_byte,
    input  logic                 room,
    output logic                 take,
    output logic                 push,
    output wsd_pkg::wsd_result_t result
);

    localparam logic [2:0] PH_HDR0  = 3'd0;
    localparam logic [2:0] PH_HDR1  = 3'd1;
    localparam logic [2:0] PH_LEN16 = 3'd2;
    localparam logic [2:0] PH_LEN64 = 3'd3;
    localparam logic [2:0] PH_KEY   = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;

    logic [2:0]  phase_reg,  phase_next;
    logic [2:0]  idx_reg,    idx_next;
    logic [63:0] acc_reg,    acc_next;
    logic [63:0] rem_reg,    rem_next;
    logic [31:0] key_reg,    key_next;
    logic        mask_reg,   mask_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic [1:0]  kpos_reg,   kpos_next;

    logic        emit;
    logic [7:0]  emit_byte;
    logic        emit_data;
    logic        emit_last;
    logic        len_done;
    logic        pay_start;
    logic [63:0] new_len;
    logic [63:0] acc_shift;
    logic [7:0]  kb;

    assign take = held_valid && room;
    assign push = take && emit;

    // key byte for the current payload position, first key byte on top
    always_comb
    begin
        case (kpos_reg)
            2'd0:    kb = key_reg[31:24];
            2'd1:    kb = key_reg[23:16];
            2'd2:    kb = key_reg[15:8];
            default: kb = key_reg[7:0];
        endcase
        if (!mask_reg)
        begin
            kb = 8'h00;
        end
    end

    assign acc_shift = {acc_reg[55:0], held_byte};

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        mask_next   = mask_reg;
        opcode_next = opcode_reg;
        kpos_next   = kpos_reg;
        emit        = 1'b0;
        emit_byte   = 8'h00;
        emit_data   = 1'b0;
        emit_last   = 1'b0;
        len_done    = 1'b0;
        pay_start   = 1'b0;
        new_len     = rem_reg;

        unique case (phase_reg) inside
            PH_HDR1:
            begin
                mask_next = held_byte[7];
                idx_next  = 3'd0;
                acc_next  = 64'd0;
                if (held_byte[6:0] == wsd_pkg::LEN_EXT16)
                begin
                    phase_next = PH_LEN16;
                end
                else if (held_byte[6:0] == wsd_pkg::LEN_EXT64)
                begin
                    phase_next = PH_LEN64;
                end
                else
                begin
                    new_len  = {57'd0, held_byte[6:0]};
                    len_done = 1'b1;
                end
            end
            PH_LEN16, PH_LEN64:
            begin
                acc_next = acc_shift;
                if (idx_reg == ((phase_reg == PH_LEN16) ? 3'd1 : 3'd7))
                begin
                    new_len  = acc_shift;
                    len_done = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            PH_KEY:
            begin
                key_next = {key_reg[23:0], held_byte};
                if (idx_reg >= 3'd3)
                begin
                    pay_start = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            PH_DATA:
            begin
                kpos_next = kpos_reg + 2'd1;
                rem_next  = rem_reg - 64'd1;
                emit      = 1'b1;
                emit_byte = held_byte ^ kb;
                emit_data = 1'b1;
                // last byte when the count is about to reach zero
                if (rem_reg == 64'd1)
                begin
                    emit_last  = 1'b1;
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                // header first byte, also any unused phase code
                opcode_next = held_byte[3:0];
                phase_next  = PH_HDR1;
            end
        endcase

        // length known: key next if masked, else straight to payload
        if (len_done)
        begin
            rem_next = new_len;
            idx_next = 3'd0;
            if (mask_next)
            begin
                key_next   = 32'd0;
                phase_next = PH_KEY;
            end
            else
            begin
                pay_start = 1'b1;
            end
        end

        // payload start: a zero length frame gives a lone end marker, else the payload phase follows
        if (pay_start)
        begin
            kpos_next = 2'd0;
            idx_next  = 3'd0;
            if (new_len == 64'd0)
            begin
                emit       = 1'b1;
                emit_last  = 1'b1;
                phase_next = PH_HDR0;
            end
            else
            begin
                phase_next = PH_DATA;
            end
        end
    end

    assign result.payload_byte = emit_byte;
    assign result.data_valid   = emit_data;
    assign result.frame_last   = emit_last;
    assign result.frame_opcode = opcode_reg;
    assign result.is_close     = (opcode_reg == wsd_pkg::OPCODE_CLOSE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            idx_reg    <= 3'd0;
            acc_reg    <= 64'd0;
            rem_reg    <= 64'd0;
            key_reg    <= 32'd0;
            mask_reg   <= 1'b0;
            opcode_reg <= 4'd0;
            kpos_reg   <= 2'd0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            acc_reg    <= acc_next;
            rem_reg    <= rem_next;
            key_reg    <= key_next;
            mask_reg   <= mask_next;
            opcode_reg <= opcode_next;
            kpos_reg   <= kpos_next;
        end
    end

`ifndef ASSERT_OFF
    // payload phase always has bytes left to take
    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> rem_reg != 64'd0)
        else $error("payload phase with zero bytes remaining");

    // a frame's final result sends the parser back to header parsing
    a_last_to_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        push && result.frame_last |=> phase_reg == PH_HDR0)
        else $error("parser did not return to header after frame end");

    // key phase only for masked frames, at most four key bytes
    a_key_phase: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_KEY |-> mask_reg && idx_reg <= 3'd3)
        else $error("bad key phase state");
`endif

endmodule

// ===== sv/wsd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// wsd_out_fifo
// two entry result register with skid, parts the parser from the consumer
// ----------------------------------------------------------------------------
module wsd_out_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  wsd_pkg::wsd_result_t push_data,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_stall,
    output wsd_pkg::wsd_result_t head
);

    wsd_pkg::wsd_result_t ent0_reg, ent0_next;
    wsd_pkg::wsd_result_t ent1_reg, ent1_next;
    logic [1:0]           count_reg, count_next;
    logic                 pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign room      = (count_reg != 2'd2);
    assign head      = ent0_reg;

    always_comb
    begin
        ent0_next  = ent0_reg;
        ent1_next  = ent1_reg;
        count_next = count_reg;
        if (pop && push)
        begin
            ent0_next = push_data;
        end
        else if (pop)
        begin
            ent0_next  = ent1_reg;
            count_next = count_reg - 2'd1;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                ent0_next = push_data;
            end
            else
            begin
                ent1_next = push_data;
            end
            count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

`ifndef ASSERT_OFF
    // parser never pushes into a full buffer, and the count stays bounded
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3 && !(push && count_reg == 2'd2))
        else $error("result buffer overflow");
`endif

endmodule

// ===== sv/websocket_frame_deframer.sv =====
// path: an accepted byte is held in the input register, passes the parser step and is written into the result buffer
// throughput: one byte per cycle while the result buffer has room, set by the single-pass parser step between
// the input register and the two entry result buffer
// header, extended-length and key bytes give no result; an empty frame gives one end marker
// reset (rst_n low, asynchronous) clears the parser to header parsing and
// empties both registers; no clearing pass
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// parses websocket frames from a byte stream and unmasks the payload
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
    input  logic       clk,
    input  logic       rst_n,
    // received byte stream
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    // result words
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] payload_byte,
    output logic       data_valid,
    output logic       frame_last,
    output logic [3:0] frame_opcode,
    output logic       is_close
);

    // input register to parser
    logic                 held_valid;
    logic [7:0]           held_byte;
    logic                 take;

    // parser to result buffer
    logic                 push;
    logic                 room;
    wsd_pkg::wsd_result_t result;
    wsd_pkg::wsd_result_t head;

    // input register; stall follows registered state only
    wsd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .take       (take),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    // header and length parsing, key capture, unmasking
    wsd_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .room       (room),
        .take       (take),
        .push       (push),
        .result     (result)
    );

    // result buffer, two entries so the parser can push one more result while the head word is stalled
    wsd_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (result),
        .room       (room),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .head       (head)
    );

    // unpack the head word onto the ports
    assign payload_byte = head.payload_byte;
    assign data_valid   = head.data_valid;
    assign frame_last   = head.frame_last;
    assign frame_opcode = head.frame_opcode;
    assign is_close     = head.is_close;

endmodule
